/* sv/srpd_pkg.sv */
// Shared types and constants for the sensor reply packet deframer.
package srpd_pkg;

    localparam int DEFAULT_MAX_PAYLOAD = 256;
    localparam logic [15:0] START_CODE_RESET = 16'hEF01;
    localparam int TDATA_W = 24;

    typedef enum logic [2:0] {
        PH_HUNT       = 3'd0,
        PH_START_LOW  = 3'd1,
        PH_ADDRESS    = 3'd2,
        PH_TYPE       = 3'd3,
        PH_LEN_HIGH   = 3'd4,
        PH_LEN_LOW    = 3'd5,
        PH_PAYLOAD    = 3'd6,
        PH_CHECKSUM   = 3'd7
    } srpd_phase_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_START = 2'd1,
        STATUS_BAD_LEN   = 2'd2,
        STATUS_BAD_SUM   = 2'd3
    } srpd_status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } srpd_kind_t;

    typedef struct packed {
        srpd_kind_t   item_kind;
        logic [7:0]   payload_byte;
        logic [7:0]   packet_type;
        srpd_status_t status;
        logic         last;
    } srpd_result_t;

endpackage

/* sv/sensor_reply_packet_deframer.sv */
// Top level of the sensor reply packet deframer.
// The slave stream takes one received serial byte per request in s_tdata[7:0].
// The master stream gives one request per payload byte (m_tuser 0) and one
// status request at the end of each packet or on an error (m_tuser 1, m_tlast 1).
// Status codes are ok, bad start byte, bad length and checksum mismatch.
// Each byte is parsed in the cycle it is accepted; its result, if any, is registered in the
// output buffer (main entry, or skid entry while main is full) before it is valid on the master side.
// Throughput is one byte per cycle while the output buffer is not full, set by the
// parser, which decodes each byte when accepted, and the two-entry buffer behind it.
// When the receiver stalls, one more result is held in the skid entry and
// s_tready drops only once both entries are full.
// The user must write the start code through cfg_wr_en and cfg_wr_data only while idle; the block does not enforce it.
// A synchronous active-low reset returns the parser to hunting for the start
// byte, empties the output buffer and restores the start code to its default.
module sensor_reply_packet_deframer
    import srpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // payload_byte, packet_type, status, zero fill
    output logic               m_tuser,   // item_kind
    output logic               m_tlast
);

    logic [15:0]  start_code_reg;
    logic         accept;
    logic         res_valid;
    srpd_result_t res;
    srpd_result_t out_res;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_code_reg <= START_CODE_RESET;
        end else if (cfg_wr_en) begin
            start_code_reg <= cfg_wr_data;
        end
    end

    srpd_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_byte   (s_tdata),
        .start_code(start_code_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    srpd_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_data  (res),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_data (out_res),
        .out_ready(m_tready)
    );

    assign m_tdata = {6'd0, out_res.status, out_res.packet_type, out_res.payload_byte};
    assign m_tuser = out_res.item_kind;
    assign m_tlast = out_res.last;

`ifndef SYNTHESIS
    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == m_tuser))
        else $error("last flag does not match status kind");

    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_PAYLOAD)) |-> (m_tdata[17:16] == STATUS_OK))
        else $error("payload request carries a nonzero status");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled while output buffer is empty");

    a_status_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_STATUS)) |-> (m_tdata[7:0] == 8'd0))
        else $error("status request carries a payload byte");
`endif

endmodule

/* sv/srpd_parser.sv */
// Packet header, payload and checksum parser for one received byte per cycle.
module srpd_parser
    import srpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  logic [7:0]   in_byte,
    input  logic [15:0]  start_code,
    output logic         res_valid,
    output srpd_result_t res
);

    localparam int PLEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int CNT_W = (PLEN_W > 2) ? PLEN_W : 2;
    localparam logic [CNT_W-1:0] ADDR_LAST = CNT_W'(3);

    srpd_phase_t       phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        len_high_reg, len_high_next;
    logic [PLEN_W-1:0] plen_reg, plen_next;
    logic [15:0]       sum_reg, sum_next;
    logic [7:0]        type_reg, type_next;
    logic [7:0]        chk_high_reg, chk_high_next;

    logic [15:0]       len_full;
    logic [15:0]       len_minus;
    logic [15:0]       sum_add;
    logic [CNT_W-1:0]  cnt_inc;
    logic              len_bad;

    assign len_full  = {len_high_reg, in_byte};
    assign len_minus = len_full - 16'd2;
    assign len_bad   = (len_full < 16'd2) || (len_minus > 16'(MAX_PAYLOAD));
    assign sum_add   = sum_reg + {8'd0, in_byte};
    assign cnt_inc   = cnt_reg + CNT_W'(1);

    always_comb begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        len_high_next = len_high_reg;
        plen_next     = plen_reg;
        sum_next      = sum_reg;
        type_next     = type_reg;
        chk_high_next = chk_high_reg;
        res_valid     = 1'b0;
        res           = '0;
        if (in_valid) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (in_byte == start_code[15:8]) begin
                        phase_next = PH_START_LOW;
                    end
                end
                PH_START_LOW: begin
                    cnt_next = '0;
                    if (in_byte != start_code[7:0]) begin
                        res_valid     = 1'b1;
                        res.item_kind = KIND_STATUS;
                        res.status    = STATUS_BAD_START;
                        res.last      = 1'b1;
                        phase_next    = PH_HUNT;
                    end else begin
                        phase_next = PH_ADDRESS;
                    end
                end
                PH_ADDRESS: begin
                    if (cnt_reg == ADDR_LAST) begin
                        phase_next = PH_TYPE;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
                PH_TYPE: begin
                    type_next  = in_byte;
                    sum_next   = {8'd0, in_byte};
                    phase_next = PH_LEN_HIGH;
                end
                PH_LEN_HIGH: begin
                    len_high_next = in_byte;
                    sum_next      = sum_add;
                    phase_next    = PH_LEN_LOW;
                end
                PH_LEN_LOW: begin
                    sum_next = sum_add;
                    cnt_next = '0;
                    if (len_bad) begin
                        res_valid       = 1'b1;
                        res.item_kind   = KIND_STATUS;
                        res.packet_type = type_reg;
                        res.status      = STATUS_BAD_LEN;
                        res.last        = 1'b1;
                        phase_next      = PH_HUNT;
                    end else begin
                        plen_next  = len_minus[PLEN_W-1:0];
                        phase_next = (len_minus == 16'd0) ? PH_CHECKSUM : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    sum_next = sum_add;
                    if (cnt_inc == CNT_W'(plen_reg)) begin
                        phase_next = PH_CHECKSUM;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                    res_valid        = 1'b1;
                    res.item_kind    = KIND_PAYLOAD;
                    res.payload_byte = in_byte;
                    res.packet_type  = type_reg;
                    res.status       = STATUS_OK;
                end
                PH_CHECKSUM: begin
                    if (cnt_reg == '0) begin
                        chk_high_next = in_byte;
                        cnt_next      = CNT_W'(1);
                    end else begin
                        res_valid       = 1'b1;
                        res.item_kind   = KIND_STATUS;
                        res.packet_type = type_reg;
                        res.status      = ({chk_high_reg, in_byte} == sum_reg) ?
                                          STATUS_OK : STATUS_BAD_SUM;
                        res.last        = 1'b1;
                        phase_next      = PH_HUNT;
                        cnt_next        = '0;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                    cnt_next   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT;
            cnt_reg      <= '0;
            len_high_reg <= '0;
            plen_reg     <= '0;
            sum_reg      <= '0;
            type_reg     <= '0;
            chk_high_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            len_high_reg <= len_high_next;
            plen_reg     <= plen_next;
            sum_reg      <= sum_next;
            type_reg     <= type_next;
            chk_high_reg <= chk_high_next;
        end
    end

endmodule

/* sv/srpd_out_buf.sv */
// Two-entry output register with skid stage for deframer results.
module srpd_out_buf
    import srpd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  srpd_result_t in_data,
    output logic         in_ready,
    output logic         out_valid,
    output srpd_result_t out_data,
    input  logic         out_ready
);

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    srpd_result_t main_data_reg, main_data_next;
    srpd_result_t skid_data_reg, skid_data_next;
    logic         pop;

    assign pop       = main_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (in_valid) begin
                main_data_next = in_data;
            end else begin
                main_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!main_valid_reg) begin
                main_data_next  = in_data;
                main_valid_next = 1'b1;
            end else begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
